/* hdl/sprt_pkg.sv */
// Shared types and constants for the serial pattern randomness test core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sprt_pkg;

	// Default sizing for the top level parameters
	localparam int DEF_MAX_BLOCK_LEN = 10;
	localparam int DEF_MAX_SEQ_BYTES = 1048576;

	// Field widths
	localparam int DATA_W    = 8;
	localparam int CNT_W     = 24;
	localparam int SUM_W     = 47;
	localparam int STAT_W    = 58;
	localparam int LIM_W     = 57;
	localparam int LEN_W     = 5;
	localparam int BLEN_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 57;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SECOND = 2'd2;

	localparam logic [BLEN_W-1:0] BLOCK_LEN_RESET = 4'd3;
	localparam int MIN_BLOCK_LEN = 3;

	// Sequencer step counts
	localparam int BYTE_LAST_BIT = 7;
	localparam int DRAIN_LAST    = 2;

	// Number of folded histograms (m, m-1, m-2)
	localparam int NFOLD = 3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BITS,
		ST_WRAP,
		ST_WALK,
		ST_DRAIN,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_LOAD
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // take a new byte
		logic bit_step;   // shift one data bit
		logic wrap_step;  // shift one kept head bit
		logic seq_start;  // latch m and short flag, clear sums
		logic walk_step;  // read and zero one histogram entry
		logic walk_acc;   // fold the entry into the sums
		logic seq_clear;  // clear window, head and bit count
		logic fin1;
		logic fin2;
		logic fin3;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_full;
	} status_t;

endpackage

/* hdl/sprt_if.sv */
// Request channel interfaces for the serial pattern randomness test core.
// Depends on sprt_pkg for field widths.
`timescale 1ns / 1ps

interface sprt_in_if import sprt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface sprt_out_if import sprt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [STAT_W-1:0] stat_first;
	logic signed [STAT_W-1:0] stat_second;
	logic                     pass_first;
	logic                     pass_second;
	logic                     too_short;

	modport source(output valid, stat_first, stat_second, pass_first, pass_second,
		too_short, input ready);
	modport sink(input valid, stat_first, stat_second, pass_first, pass_second,
		too_short, output ready);
endinterface

/* hdl/serial_pattern_randomness_test_core.sv */
// Serial pattern randomness test core: each byte is shifted in bit by bit, one histogram
// read-modify-write per bit; bytes can follow back to back.
// Final byte: bit steps, then wrap steps for the kept head bits, a walk over all 2^MAX_BLOCK_LEN
// histogram entries, a drain and the finish states FIN1, FIN2, FIN3 and LOAD; the walk dominates.
// After reset a clearing pass over all 2^MAX_BLOCK_LEN entries zeroes the histogram;
// no request is taken meanwhile, configuration writes are.
`timescale 1ns / 1ps

module serial_pattern_randomness_test_core import sprt_pkg::*; #(
	parameter int MAX_BLOCK_LEN = DEF_MAX_BLOCK_LEN,
	parameter int MAX_SEQ_BYTES = DEF_MAX_SEQ_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sprt_in_if.sink              in_ch,
	sprt_out_if.source           out_ch
);

	cmd_t    cmd;
	status_t status;

	sprt_ctrl #(
		.MAX_BLOCK_LEN(MAX_BLOCK_LEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last_byte),
		.in_ready (in_ch.ready),
		.status   (status),
		.out_ready(out_ch.ready),
		.cmd      (cmd)
	);

	sprt_dp #(
		.MAX_BLOCK_LEN(MAX_BLOCK_LEN),
		.MAX_SEQ_BYTES(MAX_SEQ_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_byte  (in_ch.data_byte),
		.cmd        (cmd),
		.status     (status),
		.stat_first (out_ch.stat_first),
		.stat_second(out_ch.stat_second),
		.pass_first (out_ch.pass_first),
		.pass_second(out_ch.pass_second),
		.too_short  (out_ch.too_short),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready)
	);

endmodule

/* hdl/sprt_ctrl.sv */
// Sequencer for the serial pattern randomness test: bit steps, wrap, histogram walk, finish.
// Depends on sprt_pkg.
`timescale 1ns / 1ps

module sprt_ctrl import sprt_pkg::*; #(
	parameter int MAX_BLOCK_LEN = DEF_MAX_BLOCK_LEN
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t status,
	input  logic    out_ready,
	output cmd_t    cmd
);

	localparam int IW = MAX_BLOCK_LEN;

	state_t        state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic          last_q;
	logic          accept;
	logic          cnt_clr;

	assign accept  = in_valid && in_ready;
	assign cnt_clr = (state_d != state_q) || accept;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_BITS;
			end
			ST_BITS: begin
				if (cnt_q == IW'(BYTE_LAST_BIT)) begin
					if (last_q) state_d = ST_WRAP;
					else if (in_valid) state_d = ST_BITS;
					else state_d = ST_IDLE;
				end
			end
			ST_WRAP: begin
				if (cnt_q == IW'(MAX_BLOCK_LEN - 2)) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (cnt_q == '1) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (cnt_q == IW'(DRAIN_LAST)) state_d = ST_FIN1;
			end
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = ST_FIN3;
			ST_FIN3: state_d = ST_LOAD;
			ST_LOAD: begin
				if (!status.out_full || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.walk_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_BITS: begin
				cmd.bit_step = 1'b1;
				in_ready     = (cnt_q == IW'(BYTE_LAST_BIT)) && !last_q;
			end
			ST_WRAP: begin
				cmd.wrap_step = 1'b1;
				cmd.seq_start = (cnt_q == '0);
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.walk_acc  = 1'b1;
				cmd.seq_clear = (cnt_q == '0);
			end
			ST_DRAIN: ;
			ST_FIN1: cmd.fin1 = 1'b1;
			ST_FIN2: cmd.fin2 = 1'b1;
			ST_FIN3: cmd.fin3 = 1'b1;
			ST_LOAD: cmd.out_load = !status.out_full || out_ready;
			default: ;
		endcase
		cmd.load = accept;
	end

	// State, step counter and final-byte flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			if (accept) last_q <= in_last;
		end
	end

	// A request taken always starts a byte of bit steps
	a_accept_bits: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_BITS && cnt_q == '0)
		else $error("accepted byte did not start bit steps");

	// Result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!status.out_full || out_ready))
		else $error("result loaded while output held");

	// Final byte always goes on to the wrap
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BITS && cnt_q == IW'(BYTE_LAST_BIT) && last_q) |=> state_q == ST_WRAP)
		else $error("final byte skipped the wrap");

	// No request taken while the histogram is being walked
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_CLEAR) |-> !in_ready)
		else $error("request taken during walk");

endmodule

/* hdl/sprt_dp.sv */
// Datapath of the serial pattern randomness test: pattern histogram memory with
// read-modify-write, fold of three square sums, final statistics. Depends on sprt_pkg.
`timescale 1ns / 1ps

module sprt_dp import sprt_pkg::*; #(
	parameter int MAX_BLOCK_LEN = DEF_MAX_BLOCK_LEN,
	parameter int MAX_SEQ_BYTES = DEF_MAX_SEQ_BYTES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic [DATA_W-1:0]        data_byte,
	input  cmd_t                     cmd,
	output status_t                  status,
	output logic signed [STAT_W-1:0] stat_first,
	output logic signed [STAT_W-1:0] stat_second,
	output logic                     pass_first,
	output logic                     pass_second,
	output logic                     too_short,
	output logic                     out_valid,
	input  logic                     out_ready
);

	localparam int IW       = MAX_BLOCK_LEN;
	localparam int DEPTH    = 2 ** IW;
	localparam int HW       = MAX_BLOCK_LEN - 1;
	localparam int MAX_BITS = MAX_SEQ_BYTES * 8;
	localparam int TW       = $clog2(MAX_BITS + MAX_BLOCK_LEN);

	// Configuration registers
	logic [BLEN_W-1:0] block_len_q;
	logic [LIM_W-1:0]  lim1_q, lim2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= BLOCK_LEN_RESET;
			lim1_q      <= '0;
			lim2_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_LEN:    block_len_q <= cfg_data[BLEN_W-1:0];
				CFG_LIMIT_FIRST:  lim1_q      <= cfg_data[LIM_W-1:0];
				CFG_LIMIT_SECOND: lim2_q      <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Bit source: byte shifter or kept head bits
	logic [DATA_W-1:0] byte_q;
	logic [IW-1:0]     win_q, win_d;
	logic [HW-1:0]     head_q, head_d;
	logic [TW-1:0]     total_q;
	logic              bit_in, take, counted, issue;
	logic [IW-1:0]     idx_q, addr;

	assign bit_in  = cmd.wrap_step ? head_q[HW-1] : byte_q[DATA_W-1];
	assign take    = (cmd.bit_step && (total_q < TW'(MAX_BITS))) || cmd.wrap_step;
	assign win_d   = {win_q[IW-2:0], bit_in};
	assign counted = take && (total_q >= TW'(HW));
	assign issue   = counted || cmd.walk_step;
	assign addr    = cmd.walk_step ? idx_q : win_d;

	// Head capture, first bit lands in the top position
	always_comb begin
		head_d = head_q;
		if (cmd.wrap_step) begin
			head_d = {head_q[HW-2:0], 1'b0};
		end else begin
			for (int j = 0; j < HW; j++) begin
				if (total_q == TW'(HW - 1 - j)) head_d[j] = bit_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) byte_q <= data_byte;
		else if (cmd.bit_step) byte_q <= {byte_q[DATA_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			head_q  <= '0;
			total_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.seq_clear) begin
				win_q   <= '0;
				head_q  <= '0;
				total_q <= '0;
			end else if (take) begin
				win_q   <= win_d;
				head_q  <= head_d;
				total_q <= total_q + 1'b1;
			end
			if (cmd.walk_step) idx_q <= idx_q + 1'b1;
		end
	end

	// Histogram memory, one read and one write a cycle
	logic [CNT_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] rd_q, base, wdata, fwd_s1;
	logic [IW-1:0]    addr_s1;
	logic             v_s1, walk_s1, acc_s1, haz_s1;

	// Forward the write in flight when the next read hits the same entry
	assign base  = haz_s1 ? fwd_s1 : rd_q;
	assign wdata = walk_s1 ? '0 : base + 1'b1;

	always_ff @(posedge clk) begin
		if (v_s1) mem[addr_s1] <= wdata;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		fwd_s1  <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			walk_s1 <= 1'b0;
			acc_s1  <= 1'b0;
			haz_s1  <= 1'b0;
		end else begin
			v_s1    <= issue;
			walk_s1 <= cmd.walk_step;
			acc_s1  <= cmd.walk_acc;
			haz_s1  <= v_s1 && (addr_s1 == addr);
		end
	end

	// Block length and fold masks, taken at the end of the sequence
	logic [LEN_W-1:0] bl_ext, m_d, m_q;
	logic [IW-1:0]    mask_q [NFOLD];
	logic             short_q;

	assign bl_ext = {1'b0, block_len_q};
	always_comb begin
		m_d = bl_ext;
		if (bl_ext < LEN_W'(MIN_BLOCK_LEN)) m_d = LEN_W'(MIN_BLOCK_LEN);
		else if (bl_ext > LEN_W'(MAX_BLOCK_LEN)) m_d = LEN_W'(MAX_BLOCK_LEN);
	end

	always_ff @(posedge clk) begin
		if (cmd.seq_start) begin
			m_q     <= m_d;
			short_q <= total_q < TW'(m_d);
			for (int k = 0; k < NFOLD; k++) begin
				mask_q[k] <= ~({IW{1'b1}} << (LEN_W'(MAX_BLOCK_LEN) - m_d + LEN_W'(k)));
			end
		end
	end

	// Fold: group runs, square, accumulate
	logic [CNT_W-1:0]   run_q  [NFOLD];
	logic [CNT_W-1:0]   sq_s2  [NFOLD];
	logic [2*CNT_W-1:0] sqp    [NFOLD];
	logic [SUM_W-1:0]   prod_s3[NFOLD];
	logic [SUM_W-1:0]   sum_q  [NFOLD];
	logic [NFOLD-1:0]   sqv_s2, pv_s3, grp_end;

	// grp_end marks the last entry of a run for each folded length
	always_comb begin
		for (int k = 0; k < NFOLD; k++) begin
			sqp[k]     = sq_s2[k] * sq_s2[k];
			grp_end[k] = walk_s1 && acc_s1 && ((addr_s1 & mask_q[k]) == mask_q[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NFOLD; k++) begin
			if (grp_end[k]) sq_s2[k] <= run_q[k] + base;
			prod_s3[k] <= sqp[k][SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s2 <= '0;
			pv_s3  <= '0;
			for (int k = 0; k < NFOLD; k++) begin
				run_q[k] <= '0;
				sum_q[k] <= '0;
			end
		end else begin
			pv_s3  <= sqv_s2;
			sqv_s2 <= grp_end;
			for (int k = 0; k < NFOLD; k++) begin
				if (grp_end[k]) run_q[k] <= '0;
				else if (walk_s1 && acc_s1) run_q[k] <= run_q[k] + base;
				if (cmd.seq_start) sum_q[k] <= '0;
				else if (pv_s3[k]) sum_q[k] <= sum_q[k] + prod_s3[k];
			end
		end
	end

	// Finish: scale, combine, compare
	logic [STAT_W-1:0] a_q, b_q, c_q, d_q, st1_q, st2_q;
	logic              p1_q, p2;

	assign p2 = st2_q[STAT_W-1] || (st2_q[LIM_W-1:0] <= lim2_q);

	always_ff @(posedge clk) begin
		if (cmd.fin1) begin
			a_q <= STAT_W'(sum_q[0]) << m_q;
			b_q <= STAT_W'(sum_q[1]) << (m_q - LEN_W'(1));
			c_q <= STAT_W'(sum_q[2]) << (m_q - LEN_W'(2));
		end
		if (cmd.fin2) begin
			st1_q <= a_q - b_q;
			d_q   <= a_q - (b_q << 1);
		end
		if (cmd.fin3) begin
			st2_q <= d_q + c_q;
			p1_q  <= st1_q[STAT_W-1] || (st1_q[LIM_W-1:0] <= lim1_q);
		end
	end

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			stat_first  <= short_q ? '0 : st1_q;
			stat_second <= short_q ? '0 : st2_q;
			pass_first  <= !short_q && p1_q;
			pass_second <= !short_q && p2;
			too_short   <= short_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid       = out_valid_q;
	assign status.out_full = out_valid_q;

endmodule
